// File: rtl/core/gpa_pkg.sv
package gpa_pkg;

   // Field widths of the request, response and register transactions
   localparam int MODE_W   = 2;
   localparam int PAGE_W   = 8;
   localparam int HGEN_W   = 15;
   localparam int OFFSET_W = 24;
   localparam int STATUS_W = 2;
   localparam int PAGES_W  = 9;
   localparam int BYTES_W  = 17;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EVICT = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PAGES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_BYTES   = 1'b1;

endpackage

// File: rtl/core/gpa_gen_store.sv
module gpa_gen_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   // Generation memory; an entry never written reads as zero
   logic [DATA_W-1:0] gen_mem [DEPTH];
   logic [DEPTH-1:0]  written_ff;
   logic [DATA_W-1:0] mem_q_ff;
   logic              written_q_ff;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         gen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= gen_mem[rd_addr];
      end
   end

   // Written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         written_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            written_q_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_data = written_q_ff ? mem_q_ff : '0;

endmodule

// File: rtl/core/generational_page_allocator_core.sv
// Generational page allocator.
// Request channel: start with req_mode, req_page_number and
// req_handle_generation; a transaction is taken when start is high and busy
// is low. Modes: allocate the lowest free page, get (check a handle), evict
// (check, free the page and bump its generation).
// Response channel: one transaction per request, shown on the rsp_ ports for
// a single cycle with rsp_valid high. The receiver cannot stall it.
// Register channel: csr_valid/csr_ready with csr_index and csr_wdata;
// csr_ready is always high. Write registers only while the block is idle.
// Sequence: the request is latched at the accepting edge, and the rsp_ ports
// are loaded at the end of the execute state; no new request is taken while
// busy is high in that state. The accept cycle runs the priority encoder over
// the used bitmap and issues the registered generation memory read; the
// execute cycle checks, writes back and multiplies the page index by the page size.
// Reset: every page is free, all generations read as zero, pages_in_use and
// page_bytes return to 256. The block takes requests right after reset.
module generational_page_allocator_core
   import gpa_pkg::*;
#(
   parameter int MAX_PAGES = 256,
   parameter int GEN_BITS  = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  start,
   output logic                  busy,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [PAGE_W-1:0]     req_page_number,
   input  logic [HGEN_W-1:0]     req_handle_generation,
   // response
   output logic                  rsp_valid,
   output logic [PAGE_W-1:0]     rsp_result_page,
   output logic [HGEN_W-1:0]     rsp_result_generation,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic [STATUS_W-1:0]   rsp_status,
   // registers
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W  = ($clog2(MAX_PAGES + 1) > PAGES_W) ? $clog2(MAX_PAGES + 1)
                                                              : PAGES_W;
   localparam int CMP_W  = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
   localparam int PROD_W = PW + BYTES_W;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type               state_ff;
   logic [PAGES_W-1:0]      pages_in_use_ff;
   logic [BYTES_W-1:0]      page_bytes_ff;
   logic [MAX_PAGES-1:0]    used_ff;
   logic [MAX_PAGES-1:0]    used_in;

   // latched request
   logic [MODE_W-1:0]       mode_ff;
   logic [PAGE_W-1:0]       page_ff;
   logic [HGEN_W-1:0]       hgen_ff;
   logic [PW-1:0]           addr_ff;
   logic                    found_ff;
   logic                    in_range_ff;

   logic                    accept;
   logic [CNT_W-1:0]        pages_ext;
   logic [CNT_W-1:0]        live_cnt;
   logic [MAX_PAGES-1:0]    free_vec;
   logic [PW:0]             search;
   logic [PW-1:0]           rd_addr;
   logic [GEN_BITS-1:0]     gen_rd;
   logic [GEN_BITS-1:0]     gen_inc;
   logic                    check_ok;
   logic                    evict_ok;
   logic [PROD_W-1:0]       product;
   logic [OFFSET_W-1:0]     offset;

   // Lowest set bit of the free vector, with a found flag on top
   function automatic logic [PW:0] find_free(input logic [MAX_PAGES-1:0] v);
      logic [PW:0] r;
      r = '0;
      for (int i = MAX_PAGES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, PW'(i)};
         end
      end
      return r;
   endfunction

   assign busy      = (state_ff == S_EXEC);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Effective page count, capped at the built depth
   assign pages_ext = CNT_W'(pages_in_use_ff);
   assign live_cnt  = (pages_ext > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages_ext;

   // Free pages below the page count
   always_comb begin
      for (int i = 0; i < MAX_PAGES; i++) begin
         free_vec[i] = !used_ff[i] && (CNT_W'(i) < live_cnt);
      end
   end

   assign search  = find_free(free_vec);
   assign rd_addr = (req_mode == MODE_ALLOC) ? search[PW-1:0] : PW'(req_page_number);

   gpa_gen_store #(
      .DEPTH  (MAX_PAGES),
      .ADDR_W (PW),
      .DATA_W (GEN_BITS)
   ) u_gen_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (gen_rd),
      .wr_en   (evict_ok),
      .wr_addr (addr_ff),
      .wr_data (gen_inc)
   );

   // Handle check and write-back data
   assign check_ok = in_range_ff && used_ff[addr_ff]
                     && (CMP_W'(gen_rd) == CMP_W'(hgen_ff));
   assign evict_ok = busy && (mode_ff == MODE_EVICT) && check_ok;
   assign gen_inc  = gen_rd + GEN_BITS'(1);

   // Byte offset, kept modulo 2^24
   assign product = PROD_W'(addr_ff) * PROD_W'(page_bytes_ff);
   assign offset  = OFFSET_W'(product);

   // Used bitmap update
   always_comb begin
      used_in = used_ff;
      if (busy) begin
         if (mode_ff == MODE_ALLOC && found_ff) begin
            used_in[addr_ff] = 1'b1;
         end else if (evict_ok) begin
            used_in[addr_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pages_in_use_ff <= PAGES_W'(256);
         page_bytes_ff   <= BYTES_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PAGES_IN_USE: pages_in_use_ff <= csr_wdata[PAGES_W-1:0];
            REG_PAGE_BYTES:   page_bytes_ff   <= csr_wdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_mode;
         page_ff     <= req_page_number;
         hgen_ff     <= req_handle_generation;
         addr_ff     <= rd_addr;
         found_ff    <= search[PW];
         in_range_ff <= CNT_W'(req_page_number) < live_cnt;
      end
   end

   // Sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff  <= S_IDLE;
               rsp_valid <= 1'b1;
               unique case (mode_ff) inside
                  MODE_ALLOC: begin
                     if (found_ff) begin
                        rsp_result_page       <= PAGE_W'(addr_ff);
                        rsp_result_generation <= HGEN_W'(gen_rd);
                        rsp_byte_offset       <= offset;
                        rsp_status            <= ST_OK;
                     end else begin
                        rsp_result_page       <= '0;
                        rsp_result_generation <= '0;
                        rsp_byte_offset       <= '0;
                        rsp_status            <= ST_FULL;
                     end
                  end
                  MODE_GET, MODE_EVICT: begin
                     rsp_result_page <= page_ff;
                     if (!check_ok) begin
                        rsp_result_generation <= '0;
                        rsp_byte_offset       <= '0;
                        rsp_status            <= ST_STALE;
                     end else begin
                        // evict reports the bumped generation
                        rsp_result_generation <= (mode_ff == MODE_EVICT)
                                                 ? HGEN_W'(gen_inc) : HGEN_W'(gen_rd);
                        rsp_byte_offset       <= offset;
                        rsp_status            <= ST_OK;
                     end
                  end
                  default: begin
                     rsp_result_page       <= '0;
                     rsp_result_generation <= '0;
                     rsp_byte_offset       <= '0;
                     rsp_status            <= ST_STALE;
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
